>>> hdl/twc_pkg.sv
// Shared types and constants for the two-way write-back cache.
package twc_pkg;
    localparam int SETS_DEF = 4;
    localparam int WAYS_DEF = 2;
    localparam int TAG_SHIFT = 7;
    localparam int SET_SHIFT = 5;
    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        KIND_READ   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_FLUSH  = 2'd2,
        KIND_REFILL = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        RK_DONE     = 3'd0,
        RK_WB       = 3'd1,
        RK_REQ      = 3'd2,
        RK_FLUSHED  = 3'd3,
        RK_REJECT   = 3'd4
    } rkind_t;

    // One accepted item as it travels from the front to the back part.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [63:0] data;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_WB,
        ST_FLUSH,
        ST_FLUSH_WB,
        ST_FILL_RD,
        ST_FILL_OUT
    } state_t;
endpackage

>>> hdl/twc_front.sv
// Input side: takes beats from the input channel into a short queue.
module twc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           valid,
    output logic           stall,
    input  logic [1:0]     kind,
    input  logic [15:0]    address,
    input  logic [63:0]    data,
    output logic           q_valid,
    input  logic           q_take,
    output twc_pkg::item_t q_item
);
    twc_pkg::item_t mem_reg [twc_pkg::QDEPTH];
    logic wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push, pop;

    assign stall   = (cnt_reg == 2'd2);
    assign push    = valid && !stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_take && q_valid;
    assign q_item  = mem_reg[rp_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store the beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= '{kind: kind, address: address, data: data};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> stall)
        else $error("full queue must stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 && !push) |=> !q_valid)
        else $error("empty queue shows an item");
endmodule

>>> hdl/twc_back.sv
// Back part: tag check, line store, write-back, refill and flush sequencing.
module twc_back #(
    parameter int SETS = twc_pkg::SETS_DEF,
    parameter int WAYS = twc_pkg::WAYS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_take,
    input  twc_pkg::item_t q_item,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [2:0]     result_kind,
    output logic [15:0]    mem_address,
    output logic [63:0]    result_data,
    output logic           hit,
    output logic           compulsory,
    output logic           misaligned,
    output logic           last
);
    localparam int SLOTS = SETS * WAYS;
    localparam int SW = $clog2(SETS);
    localparam int LW = $clog2(SLOTS);

    // Line storage and tags
    logic [63:0] beats_mem [SLOTS * 4];
    logic [8:0]  tag_reg [SLOTS];
    logic [SLOTS-1:0] valid_reg, dirty_reg;
    logic [SETS-1:0]  lru_reg;

    twc_pkg::state_t state_reg, state_next;
    twc_pkg::item_t  cur_reg;
    logic        waiting_reg;
    logic [1:0]  bc_reg;
    logic        p_write_reg, p_way_reg, p_comp_reg;
    logic [15:0] p_addr_reg;
    logic [31:0] p_word_reg;
    logic [LW-1:0] wb_slot_reg;
    logic [1:0]  wb_beat_reg;
    logic [LW-1:0] fl_slot_reg;
    logic        after_wb_req_reg;

    // Memory read port, registered
    logic [LW+1:0] rd_addr;
    logic [63:0]   rd_data_reg;
    logic          mem_we;
    logic [LW+1:0] wr_addr;
    logic [63:0]   wr_data;

    // Output register
    logic          ov_reg;
    logic [2:0]    ok_reg;
    logic [15:0]   oa_reg;
    logic [63:0]   od_reg;
    logic          oh_reg, oc_reg, om_reg, ol_reg;
    logic          o_load;
    logic [2:0]    nk;
    logic [15:0]   na;
    logic [63:0]   nd;
    logic          nh, nc, nm, nl;
    logic          out_free;

    logic [SW-1:0] cset;
    logic [8:0]    ctag;
    logic [LW-1:0] s0, s1, ps, vs;
    logic          h0, h1;

    assign out_free    = !ov_reg || !out_stall;
    assign out_valid   = ov_reg;
    assign result_kind = ok_reg;
    assign mem_address = oa_reg;
    assign result_data = od_reg;
    assign hit         = oh_reg;
    assign compulsory  = oc_reg;
    assign misaligned  = om_reg;
    assign last        = ol_reg;

    assign cset = cur_reg.address[twc_pkg::SET_SHIFT +: SW];
    assign ctag = cur_reg.address[15:twc_pkg::TAG_SHIFT];
    assign s0   = {cset, 1'b0};
    assign s1   = {cset, 1'b1};
    assign h0   = valid_reg[s0] && tag_reg[s0] == ctag;
    assign h1   = valid_reg[s1] && tag_reg[s1] == ctag;
    assign ps   = {p_addr_reg[twc_pkg::SET_SHIFT +: SW], p_way_reg};
    // Victim slot when both ways are valid
    assign vs   = (valid_reg[s0] && valid_reg[s1]) ? {cset, lru_reg[cset]} : s0;

    // Sequence the back part and pick the next result
    always_comb
    begin
        state_next = state_reg;
        q_take = 1'b0;
        o_load = 1'b0;
        nk = twc_pkg::RK_DONE;
        na = '0;
        nd = '0;
        nh = 1'b0;
        nc = 1'b0;
        nm = 1'b0;
        nl = 1'b1;
        rd_addr = {s0, cur_reg.address[4:3]};
        mem_we = 1'b0;
        wr_addr = {ps, bc_reg};
        wr_data = cur_reg.data;
        unique case (state_reg)
            twc_pkg::ST_IDLE:
            begin
                q_take = q_valid;
                if (q_valid)
                begin
                    state_next = twc_pkg::ST_LOOK;
                end
            end
            twc_pkg::ST_LOOK:
            begin
                // Fetch the hit word, or the first beat of the victim
                rd_addr = (h0 || h1) ? {h1 ? s1 : s0, cur_reg.address[4:3]}
                                     : {vs, 2'd0};
                if (cur_reg.kind == twc_pkg::KIND_REFILL)
                begin
                    if (!waiting_reg)
                    begin
                        if (out_free)
                        begin
                            o_load = 1'b1;
                            nk = twc_pkg::RK_REJECT;
                            state_next = twc_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        state_next = (bc_reg == 2'd3) ? twc_pkg::ST_FILL_RD
                                                      : twc_pkg::ST_IDLE;
                    end
                end
                else if (waiting_reg)
                begin
                    if (out_free)
                    begin
                        o_load = 1'b1;
                        nk = twc_pkg::RK_REJECT;
                        state_next = twc_pkg::ST_IDLE;
                    end
                end
                else if (cur_reg.kind == twc_pkg::KIND_FLUSH)
                begin
                    state_next = twc_pkg::ST_FLUSH;
                end
                else if (cur_reg.address[1:0] != 2'b00)
                begin
                    if (out_free)
                    begin
                        o_load = 1'b1;
                        nm = 1'b1;
                        state_next = twc_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = twc_pkg::ST_WB;
                end
            end
            twc_pkg::ST_WB:
            begin
                // Hit result, or victim write-back then refill request
                if (h0 || h1)
                begin
                    rd_addr = {h1 ? s1 : s0, cur_reg.address[4:3]};
                end
                else
                begin
                    rd_addr = {wb_slot_reg, out_free ? wb_beat_reg + 2'd1 : wb_beat_reg};
                end
                if (out_free)
                begin
                    o_load = 1'b1;
                    if (h0 || h1)
                    begin
                        nh = 1'b1;
                        if (cur_reg.kind == twc_pkg::KIND_READ)
                        begin
                            nd = {32'd0, cur_reg.address[2] ? rd_data_reg[63:32]
                                                            : rd_data_reg[31:0]};
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            wr_addr = {h1 ? s1 : s0, cur_reg.address[4:3]};
                            wr_data = cur_reg.address[2]
                                ? {cur_reg.data[31:0], rd_data_reg[31:0]}
                                : {rd_data_reg[63:32], cur_reg.data[31:0]};
                        end
                        state_next = twc_pkg::ST_IDLE;
                    end
                    else if (after_wb_req_reg)
                    begin
                        nk = twc_pkg::RK_REQ;
                        na = {cur_reg.address[15:5], 5'd0};
                        nc = !(valid_reg[s0] && valid_reg[s1]);
                        state_next = twc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        nk = twc_pkg::RK_WB;
                        nl = 1'b0;
                        na = {tag_reg[wb_slot_reg], wb_slot_reg[LW-1:1], wb_beat_reg, 3'd0};
                        nd = rd_data_reg;
                    end
                end
            end
            twc_pkg::ST_FLUSH:
            begin
                rd_addr = {fl_slot_reg, 2'd0};
                if (dirty_reg[fl_slot_reg])
                begin
                    state_next = twc_pkg::ST_FLUSH_WB;
                end
                else if (fl_slot_reg == LW'(SLOTS - 1))
                begin
                    if (out_free)
                    begin
                        o_load = 1'b1;
                        nk = twc_pkg::RK_FLUSHED;
                        state_next = twc_pkg::ST_IDLE;
                    end
                end
            end
            twc_pkg::ST_FLUSH_WB:
            begin
                rd_addr = {fl_slot_reg, out_free ? wb_beat_reg + 2'd1 : wb_beat_reg};
                if (out_free)
                begin
                    o_load = 1'b1;
                    nk = twc_pkg::RK_WB;
                    nl = 1'b0;
                    na = {tag_reg[fl_slot_reg], fl_slot_reg[LW-1:1], wb_beat_reg, 3'd0};
                    nd = rd_data_reg;
                    if (wb_beat_reg == 2'd3)
                    begin
                        state_next = twc_pkg::ST_FLUSH;
                    end
                end
            end
            twc_pkg::ST_FILL_RD:
            begin
                rd_addr = {ps, p_addr_reg[4:3]};
                state_next = twc_pkg::ST_FILL_OUT;
            end
            twc_pkg::ST_FILL_OUT:
            begin
                rd_addr = {ps, p_addr_reg[4:3]};
                if (out_free)
                begin
                    o_load = 1'b1;
                    nc = p_comp_reg;
                    if (p_write_reg)
                    begin
                        mem_we = 1'b1;
                        wr_addr = {ps, p_addr_reg[4:3]};
                        wr_data = p_addr_reg[2] ? {p_word_reg, rd_data_reg[31:0]}
                                                : {rd_data_reg[63:32], p_word_reg};
                    end
                    else
                    begin
                        nd = {32'd0, p_addr_reg[2] ? rd_data_reg[63:32]
                                                   : rd_data_reg[31:0]};
                    end
                    state_next = twc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = twc_pkg::ST_IDLE;
            end
        endcase
    end

    // Line data memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            beats_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= beats_mem[rd_addr];
        if (q_take)
        begin
            cur_reg <= q_item;
        end
    end

    // Control state and tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= twc_pkg::ST_IDLE;
            valid_reg <= '0;
            dirty_reg <= '0;
            lru_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                tag_reg[i] <= '0;
            end
            waiting_reg <= 1'b0;
            bc_reg <= '0;
            p_write_reg <= 1'b0;
            p_way_reg <= 1'b0;
            p_comp_reg <= 1'b0;
            p_addr_reg <= '0;
            p_word_reg <= '0;
            wb_slot_reg <= '0;
            wb_beat_reg <= '0;
            fl_slot_reg <= '0;
            after_wb_req_reg <= 1'b0;
            ov_reg <= 1'b0;
            ok_reg <= '0;
            oa_reg <= '0;
            od_reg <= '0;
            oh_reg <= 1'b0;
            oc_reg <= 1'b0;
            om_reg <= 1'b0;
            ol_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (o_load)
            begin
                ov_reg <= 1'b1;
                ok_reg <= nk;
                oa_reg <= na;
                od_reg <= nd;
                oh_reg <= nh;
                oc_reg <= nc;
                om_reg <= nm;
                ol_reg <= nl;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                twc_pkg::ST_LOOK:
                begin
                    wb_beat_reg <= 2'd0;
                    fl_slot_reg <= '0;
                    if (cur_reg.kind == twc_pkg::KIND_REFILL && waiting_reg)
                    begin
                        bc_reg <= bc_reg + 2'd1;
                    end
                    else if (!waiting_reg && cur_reg.kind != twc_pkg::KIND_FLUSH
                             && cur_reg.kind != twc_pkg::KIND_REFILL
                             && cur_reg.address[1:0] == 2'b00 && !h0 && !h1)
                    begin
                        // Miss: choose the way and start refill bookkeeping
                        if (!valid_reg[s0])
                        begin
                            p_way_reg <= 1'b0;
                            after_wb_req_reg <= 1'b1;
                        end
                        else if (!valid_reg[s1])
                        begin
                            p_way_reg <= 1'b1;
                            after_wb_req_reg <= 1'b1;
                        end
                        else
                        begin
                            p_way_reg <= lru_reg[cset];
                            after_wb_req_reg <= !dirty_reg[{cset, lru_reg[cset]}];
                        end
                        wb_slot_reg <= valid_reg[s0] && valid_reg[s1]
                            ? {cset, lru_reg[cset]} : s0;
                    end
                    else
                    begin
                        wb_slot_reg <= h1 ? s1 : s0;
                    end
                end
                twc_pkg::ST_WB:
                begin
                    if (out_free)
                    begin
                        if (h0 || h1)
                        begin
                            lru_reg[cset] <= !h1;
                            if (cur_reg.kind == twc_pkg::KIND_WRITE)
                            begin
                                dirty_reg[h1 ? s1 : s0] <= 1'b1;
                            end
                        end
                        else if (after_wb_req_reg)
                        begin
                            valid_reg[{cset, p_way_reg}] <= 1'b0;
                            dirty_reg[{cset, p_way_reg}] <= 1'b0;
                            waiting_reg <= 1'b1;
                            bc_reg <= 2'd0;
                            p_write_reg <= cur_reg.kind == twc_pkg::KIND_WRITE;
                            p_addr_reg <= cur_reg.address;
                            p_word_reg <= cur_reg.kind == twc_pkg::KIND_WRITE
                                          ? cur_reg.data[31:0] : 32'd0;
                            p_comp_reg <= !(valid_reg[s0] && valid_reg[s1]);
                        end
                        else
                        begin
                            wb_beat_reg <= wb_beat_reg + 2'd1;
                            if (wb_beat_reg == 2'd3)
                            begin
                                after_wb_req_reg <= 1'b1;
                            end
                        end
                    end
                end
                twc_pkg::ST_FLUSH:
                begin
                    wb_beat_reg <= 2'd0;
                    if (!dirty_reg[fl_slot_reg] && fl_slot_reg != LW'(SLOTS - 1))
                    begin
                        fl_slot_reg <= fl_slot_reg + LW'(1);
                    end
                end
                twc_pkg::ST_FLUSH_WB:
                begin
                    if (out_free)
                    begin
                        wb_beat_reg <= wb_beat_reg + 2'd1;
                        if (wb_beat_reg == 2'd3)
                        begin
                            dirty_reg[fl_slot_reg] <= 1'b0;
                        end
                    end
                end
                twc_pkg::ST_FILL_OUT:
                begin
                    if (out_free)
                    begin
                        waiting_reg <= 1'b0;
                        bc_reg <= 2'd0;
                        tag_reg[ps] <= p_addr_reg[15:twc_pkg::TAG_SHIFT];
                        valid_reg[ps] <= 1'b1;
                        dirty_reg[ps] <= p_write_reg;
                        lru_reg[p_addr_reg[twc_pkg::SET_SHIFT +: SW]] <= !p_way_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == twc_pkg::ST_FILL_OUT) |-> waiting_reg)
        else $error("fill answer without pending refill");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> ov_reg && $stable(od_reg))
        else $error("stalled result lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (waiting_reg) |-> !valid_reg[ps])
        else $error("victim way valid during refill");
endmodule

>>> hdl/two_way_write_back_cache.sv
// Top level of the two-way write-back cache.
// Usage: items enter on valid/stall with kind, address and data; results
// leave on out_valid/out_stall with one port per field, last marking the
// final result of each item. A hit passes the queue, the tag compare and the
// registered data read. A miss with a dirty victim gives four write-back beats,
// one per cycle unless the receiver stalls, then a refill request. Each refill
// beat is written into the line; after the fourth the line word is read back,
// merged and answered. Flush walks all 8 lines, skipping clean ones and giving
// four write-back beats per dirty line. The line sequencer in the back part
// handles one item at a time; a two-entry queue in front keeps taking items
// while it works. Reset clears all tags, valid, dirty and LRU marks and
// empties the queue; line data is undefined until filled. When the receiver
// stalls, the result register holds and the sequencer waits.
module two_way_write_back_cache #(
    parameter int SETS = twc_pkg::SETS_DEF,
    parameter int WAYS = twc_pkg::WAYS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        stall,
    input  logic [1:0]  kind,
    input  logic [15:0] address,
    input  logic [63:0] data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  result_kind,
    output logic [15:0] mem_address,
    output logic [63:0] result_data,
    output logic        hit,
    output logic        compulsory,
    output logic        misaligned,
    output logic        last
);
    logic           q_valid, q_take;
    twc_pkg::item_t q_item;

    twc_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(valid), .stall(stall),
        .kind(kind), .address(address), .data(data),
        .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
    );

    twc_back #(.SETS(SETS), .WAYS(WAYS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
        .q_item(q_item), .out_valid(out_valid), .out_stall(out_stall),
        .result_kind(result_kind), .mem_address(mem_address),
        .result_data(result_data), .hit(hit), .compulsory(compulsory),
        .misaligned(misaligned), .last(last)
    );
endmodule

>>> dv/two_way_write_back_cache_tb.sv
// Self-checking testbench for the two-way write-back cache: predicts every result beat.
module two_way_write_back_cache_tb;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [63:0] data;
        logic        hold;
    } stim_t;

    typedef struct packed {
        logic [2:0]  rkind;
        logic [15:0] maddr;
        logic [63:0] rdata;
        logic        hit;
        logic        comp;
        logic        mis;
        logic        last;
    } beat_t;

    logic        clk;
    logic        rst_n;
    logic        valid;
    logic        stall;
    logic [1:0]  kind;
    logic [15:0] address;
    logic [63:0] data;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  result_kind;
    logic [15:0] mem_address;
    logic [63:0] result_data;
    logic        hit;
    logic        compulsory;
    logic        misaligned;
    logic        last;

    two_way_write_back_cache dut (.*);

    // Cache mirror used for prediction
    logic [63:0] m_beats [32];
    logic [8:0]  m_tag [8];
    logic        m_valid [8];
    logic        m_dirty [8];
    logic        m_lru [4];
    logic        m_waiting;
    logic [1:0]  m_count;
    logic        m_pwrite;
    logic [15:0] m_paddr;
    logic [31:0] m_pword;
    logic        m_pway;
    logic        m_pcomp;

    stim_t pending_items [$];
    beat_t expected_beats [$];
    int    errors;
    int    in_gap;
    int    out_gap;
    bit    stim_done;

    // Recently used addresses, reused to provoke hits
    logic [15:0] recent [8];

    function automatic beat_t mk(logic [2:0] rk, logic [15:0] ma, logic [63:0] d,
                                 logic h, logic c, logic m, logic l);
        beat_t b;
        b.rkind = rk; b.maddr = ma; b.rdata = d; b.hit = h; b.comp = c;
        b.mis = m; b.last = l;
        return b;
    endfunction

    function automatic logic [31:0] word_of(int s, logic [4:0] ofs);
        logic [63:0] b;
        b = m_beats[s * 4 + ofs[4:3]];
        return ofs[2] ? b[63:32] : b[31:0];
    endfunction

    task automatic put_word(int s, logic [4:0] ofs, logic [31:0] w);
        if (ofs[2]) m_beats[s * 4 + ofs[4:3]][63:32] = w;
        else m_beats[s * 4 + ofs[4:3]][31:0] = w;
    endtask

    task automatic emit_writeback(int set, int way);
        int s;
        logic [15:0] base;
        s = set * 2 + way;
        base = {m_tag[s], set[1:0], 5'd0};
        for (int b = 0; b < 4; b++)
            expected_beats.push_back(mk(twc_pkg::RK_WB, base + 16'(8 * b),
                                        m_beats[s * 4 + b], 0, 0, 0, 0));
        m_dirty[s] = 0;
    endtask

    // Predict the result beats of one accepted item
    task automatic predict_cache(stim_t it);
        int set, s, way;
        logic [8:0] tg;
        logic [31:0] rd;
        logic comp;
        bit found;
        found = 0;
        rd = 0;
        comp = 0;
        if (it.kind == twc_pkg::KIND_REFILL)
        begin
            if (!m_waiting)
            begin
                expected_beats.push_back(mk(twc_pkg::RK_REJECT, 0, 0, 0, 0, 0, 1));
            end
            else
            begin
                set = m_paddr[6:5];
                s = set * 2 + m_pway;
                m_beats[s * 4 + m_count] = it.data;
                if (m_count < 3)
                begin
                    m_count++;
                end
                else
                begin
                    m_count = 0;
                    m_waiting = 0;
                    m_tag[s] = m_paddr[15:7];
                    m_valid[s] = 1;
                    if (m_pwrite)
                    begin
                        put_word(s, m_paddr[4:0], m_pword);
                        m_dirty[s] = 1;
                    end
                    else
                    begin
                        m_dirty[s] = 0;
                        rd = word_of(s, m_paddr[4:0]);
                    end
                    m_lru[set] = ~m_pway;
                    expected_beats.push_back(mk(twc_pkg::RK_DONE, 0, {32'd0, rd}, 0,
                                                m_pcomp, 0, 1));
                end
            end
        end
        else if (m_waiting)
        begin
            expected_beats.push_back(mk(twc_pkg::RK_REJECT, 0, 0, 0, 0, 0, 1));
        end
        else if (it.kind == twc_pkg::KIND_FLUSH)
        begin
            for (int st = 0; st < 4; st++)
                for (int w = 0; w < 2; w++)
                    if (m_dirty[st * 2 + w]) emit_writeback(st, w);
            expected_beats.push_back(mk(twc_pkg::RK_FLUSHED, 0, 0, 0, 0, 0, 1));
        end
        else if (it.address[1:0] != 0)
        begin
            expected_beats.push_back(mk(twc_pkg::RK_DONE, 0, 0, 0, 0, 1, 1));
        end
        else
        begin
            set = it.address[6:5];
            tg = it.address[15:7];
            for (int w = 0; w < 2 && !found; w++)
            begin
                s = set * 2 + w;
                if (m_valid[s] && m_tag[s] == tg)
                begin
                    found = 1;
                    if (it.kind == twc_pkg::KIND_WRITE)
                    begin
                        put_word(s, it.address[4:0], it.data[31:0]);
                        m_dirty[s] = 1;
                    end
                    else
                    begin
                        rd = word_of(s, it.address[4:0]);
                    end
                    m_lru[set] = (w == 0);
                    expected_beats.push_back(mk(twc_pkg::RK_DONE, 0, {32'd0, rd}, 1, 0,
                                                0, 1));
                end
            end
            if (!found)
            begin
                if (!m_valid[set * 2])
                begin
                    way = 0; comp = 1;
                end
                else if (!m_valid[set * 2 + 1])
                begin
                    way = 1; comp = 1;
                end
                else
                begin
                    way = m_lru[set];
                    if (m_dirty[set * 2 + way]) emit_writeback(set, way);
                end
                m_valid[set * 2 + way] = 0;
                m_dirty[set * 2 + way] = 0;
                m_waiting = 1;
                m_count = 0;
                m_pwrite = (it.kind == twc_pkg::KIND_WRITE);
                m_paddr = it.address;
                m_pword = (it.kind == twc_pkg::KIND_WRITE) ? it.data[31:0] : 32'd0;
                m_pway = way[0];
                m_pcomp = comp;
                expected_beats.push_back(mk(twc_pkg::RK_REQ, {it.address[15:5], 5'd0}, 0,
                                            0, comp, 0, 1));
            end
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Queue one item; accesses queued with with_fill are followed by four refill beats
    task automatic add_item(logic [1:0] k, logic [15:0] a, logic [63:0] d, bit hold);
        stim_t it;
        it.kind = k; it.address = a; it.data = d; it.hold = hold;
        pending_items.push_back(it);
    endtask

    task automatic add_access(logic [1:0] k, logic [15:0] a, bit with_fill);
        add_item(k, a, rand64(), 0);
        if (with_fill)
            for (int i = 0; i < 4; i++) add_item(twc_pkg::KIND_REFILL, 0, rand64(), 0);
    endtask

    function automatic logic [15:0] pick_addr();
        logic [15:0] a;
        a = 16'($urandom());
        // Narrow the tag space so hits and evictions are frequent
        if ($urandom_range(0, 3) != 0) a[15:7] = 9'($urandom_range(0, 3)) | {9{a[15]}} & 9'h1fc;
        if ($urandom_range(0, 2) == 0) a = recent[$urandom_range(0, 7)];
        a[1:0] = ($urandom_range(0, 9) == 0) ? a[1:0] : 2'b00;
        return a;
    endfunction

    // Clock
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Stimulus: directed items first, then random traffic
    initial
    begin
        logic [15:0] a;
        int r;
        errors = 0;
        stim_done = 0;
        m_waiting = 0; m_count = 0; m_pwrite = 0; m_paddr = 0; m_pword = 0;
        m_pway = 0; m_pcomp = 0;
        for (int i = 0; i < 32; i++) m_beats[i] = 0;
        for (int i = 0; i < 8; i++)
        begin
            m_tag[i] = 0; m_valid[i] = 0; m_dirty[i] = 0; recent[i] = 16'h0;
        end
        for (int i = 0; i < 4; i++) m_lru[i] = 0;
        // Reject a stray refill beat, flush an empty cache and read a misaligned address
        add_item(twc_pkg::KIND_REFILL, 16'hffff, 64'hffff_ffff_ffff_ffff, 0);
        add_item(twc_pkg::KIND_FLUSH, 0, 0, 0);
        add_item(twc_pkg::KIND_READ, 16'h0003, 0, 0);
        // Compulsory miss, hits, writes at extremes
        add_access(twc_pkg::KIND_WRITE, 16'h0000, 1);
        add_item(twc_pkg::KIND_WRITE, 16'h001c, 64'hffff_ffff_ffff_ffff, 0);
        add_item(twc_pkg::KIND_READ, 16'h001c, 0, 0);
        add_access(twc_pkg::KIND_READ, 16'hff80, 1);
        add_item(twc_pkg::KIND_READ, 16'h0040, 0, 0);
        add_item(twc_pkg::KIND_FLUSH, 0, 0, 0);
        add_item(twc_pkg::KIND_REFILL, 0, 64'h0, 0);
        for (int i = 0; i < 4; i++)
            add_item(twc_pkg::KIND_REFILL, 0, 64'hffff_ffff_ffff_ffff, 0);
        // Two write hits on one line in set 0; the refill beats after them are rejected
        add_item(twc_pkg::KIND_WRITE, 16'hff84, 64'h1234_5678, 0);
        add_access(twc_pkg::KIND_WRITE, 16'hfffc & 16'hff9c | 16'h0100, 1);
        add_item(twc_pkg::KIND_FLUSH, 0, 0, 1);
        // Random part
        while (pending_items.size() < 440)
        begin
            r = $urandom_range(0, 99);
            a = pick_addr();
            recent[$urandom_range(0, 7)] = {a[15:2], 2'b00};
            if (r < 4) add_item(twc_pkg::KIND_FLUSH, 0, 0, 0);
            else if (r < 7) add_item(twc_pkg::KIND_REFILL, 16'($urandom()), rand64(), 0);
            else if (r < 9)
            begin
                // Broken sequence: another item comes between an access and its refill beats
                add_item(2'($urandom_range(0, 1)), a, rand64(), 0);
                add_item(2'($urandom_range(0, 2)), pick_addr(), rand64(), 0);
                for (int i = 0; i < 4; i++) add_item(twc_pkg::KIND_REFILL, 0, rand64(), 0);
            end
            else add_access(2'($urandom_range(0, 1)), a, 1);
        end
        stim_done = 1;
    end

    // Refill beats that arrive after a hit are simply rejected, which the mirror predicts

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid <= 0;
            kind <= twc_pkg::KIND_READ;
            address <= 0;
            data <= 0;
            in_gap <= 0;
        end
        else
        begin
            if (valid && !stall)
            begin
                predict_cache({kind, address, data, 1'b0});
            end
            if (!valid || !stall)
            begin
                if (in_gap > 0)
                begin
                    valid <= 0;
                    in_gap <= in_gap - 1;
                end
                else if (pending_items.size() > 0 &&
                         !(pending_items[0].hold && (expected_beats.size() > 0 ||
                           (valid && !stall))))
                begin
                    valid <= 1;
                    kind <= pending_items[0].kind;
                    address <= pending_items[0].address;
                    data <= pending_items[0].data;
                    void'(pending_items.pop_front());
                    in_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0;
                end
                else
                begin
                    valid <= 0;
                end
            end
        end
    end

    // Monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        beat_t want;
        if (!rst_n)
        begin
            out_stall <= 0;
            out_gap <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    report_mismatch("unexpected beat", result_kind, 0);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (result_kind !== want.rkind)
                        report_mismatch("result_kind", result_kind, want.rkind);
                    if (mem_address !== want.maddr)
                        report_mismatch("mem_address", mem_address, want.maddr);
                    if (result_data !== want.rdata)
                        report_mismatch("result_data", result_data, want.rdata);
                    if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
                    if (compulsory !== want.comp)
                        report_mismatch("compulsory", compulsory, want.comp);
                    if (misaligned !== want.mis)
                        report_mismatch("misaligned", misaligned, want.mis);
                    if (last !== want.last) report_mismatch("last", last, want.last);
                end
            end
            // After an accepted result beat, sometimes draw a stall stretch
            if (out_gap > 0)
            begin
                out_stall <= 1;
                out_gap <= out_gap - 1;
            end
            else
            begin
                out_stall <= 0;
                if (out_valid && !out_stall && $urandom_range(0, 2) == 0)
                    out_gap <= $urandom_range(0, 9);
            end
        end
    end

    // Reset, then wait for drain
    initial
    begin
        rst_n = 0;
        valid = 0;
        kind = twc_pkg::KIND_READ;
        address = 0;
        data = 0;
        out_stall = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        wait (stim_done && pending_items.size() == 0);
        @(posedge clk);
        while (valid || expected_beats.size() > 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_beats.size() == 0)
            $display("two_way_write_back_cache_tb OK");
        else
            $display("two_way_write_back_cache_tb NOT OK");
        $finish;
    end

    // Timeout
    initial
    begin
        #4000000;
        $display("two_way_write_back_cache_tb NOT OK");
        $finish;
    end
endmodule

>>> two_way_write_back_cache.f
hdl/twc_pkg.sv
hdl/twc_front.sv
hdl/twc_back.sv
hdl/two_way_write_back_cache.sv
dv/two_way_write_back_cache_tb.sv
